@@ rtl/hsil_pkg.sv @@
// ----------------------------------------------------------------------------
// hsil_pkg
// Shared types and constants of the hash set: opcodes, key width and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hsil_pkg;

  localparam int KeyW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd_en;
    logic rd_from_in;
    logic div_step;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

@@ rtl/hash_set_insert_lookup_delete.sv @@
// ----------------------------------------------------------------------------
// hash_set_insert_lookup_delete
// Bucketed hash set of signed 32-bit keys with insert, query and delete.
// ----------------------------------------------------------------------------
// Usage: a request (opcode_i, key_i) is a transaction on in_valid_i/in_ready_o;
// each request returns exactly one result (present_o, overflow_o) as a
// transaction on out_valid_o/out_ready_i. present_o tells whether the key was
// stored before the request; overflow_o flags an insert dropped on a full
// bucket. Opcode 3 acts as a query.
// Timing: with BUCKETS a power of two a request is accepted with the bucket
// read, then compared and written back; otherwise the bucket remainder is
// formed by a reciprocal multiply and one correction, then the bucket is read,
// compared and written back. The result is registered with the write-back; a
// new request is accepted only once the previous one has been written back.
// Reset: all valid marks are cleared by a sweep over all BUCKETS rows, one bucket
// per cycle, with in_ready_o low throughout.
// Stall: the result register holds while out_ready_i is low; one further
// request is accepted and carried up to its write-back, which waits for the register.
// ----------------------------------------------------------------------------
module hash_set_insert_lookup_delete #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               present_o,
  output logic               overflow_o
);
  import hsil_pkg::*;

  localparam bit Pow2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  cmd_t cmd;
  sts_t sts;

  hsil_ctrl #(
    .Pow2 (Pow2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hsil_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .Pow2    (Pow2)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .present_o  (present_o),
    .overflow_o (overflow_o)
  );

endmodule

@@ rtl/hsil_ram.sv @@
// ----------------------------------------------------------------------------
// hsil_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module hsil_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hsil_dp.sv @@
// ----------------------------------------------------------------------------
// hsil_dp
// Datapath of the hash set: request registers, bucket remainder unit, clear
// counter, key and valid RAMs, way compare and write-back, result register.
// ----------------------------------------------------------------------------
module hsil_dp #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4,
  parameter bit Pow2    = 1'b1,
  localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsil_pkg::cmd_t          cmd_i,
  output hsil_pkg::sts_t          sts_o,
  input  logic [1:0]              opcode_i,
  input  logic signed [31:0]      key_i,
  output logic                    present_o,
  output logic                    overflow_o
);
  import hsil_pkg::*;

  localparam logic [63:0]     RecipW   = 64'h1_0000_0000 / 64'(BUCKETS);
  localparam logic [KeyW-1:0] RecipC   = RecipW[KeyW-1:0];
  localparam logic [KeyW-1:0] BucketsC = KeyW'(BUCKETS);
  localparam logic [BW-1:0]   LastRow  = BW'(BUCKETS - 1);
  localparam int              RowW     = WAYS * KeyW;

  logic [1:0]      op_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] mag_q;
  logic [KeyW-1:0] quo_q;
  logic [BW-1:0]   rem_q;
  logic            div_cnt_q;
  logic [BW-1:0]   clr_cnt_q;
  logic            present_q;
  logic            overflow_q;

  logic [KeyW-1:0]   key_u;
  logic [KeyW-1:0]   mag_in;
  logic [2*KeyW-1:0] prod;
  logic [KeyW-1:0]   quo_b;
  logic [KeyW-1:0]   rem_diff;
  logic [KeyW-1:0]   rem_fix;
  logic [BW-1:0]     raddr;
  logic [WAYS-1:0]   vld_row;
  logic [RowW-1:0]   key_row;
  logic [WAYS-1:0]   hit_v;
  logic [WAYS-1:0]   free_v;
  logic [WAYS-1:0]   hit_first;
  logic [WAYS-1:0]   free_first;
  logic              hit_any;
  logic              free_any;
  logic              is_ins;
  logic              is_del;
  logic              do_ins;
  logic              do_del;
  logic              ovf;
  logic [WAYS-1:0]   vld_new;
  logic [RowW-1:0]   key_new;
  logic              vld_we;
  logic [BW-1:0]     vld_waddr;
  logic [WAYS-1:0]   vld_wdata;

  assign key_u    = key_i;
  assign mag_in   = key_u[KeyW-1] ? (32'd0 - key_u) : key_u;
  assign prod     = {{KeyW{1'b0}}, mag_q} * {{KeyW{1'b0}}, RecipC};
  assign quo_b    = quo_q * BucketsC;
  assign rem_diff = mag_q - quo_b;
  assign rem_fix  = (rem_diff >= BucketsC) ? (rem_diff - BucketsC) : rem_diff;
  assign raddr    = cmd_i.rd_from_in ? mag_in[BW-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        div_cnt_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= ~div_cnt_q;
      end
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_u;
      mag_q <= mag_in;
      rem_q <= Pow2 ? mag_in[BW-1:0] : '0;
    end else if (cmd_i.div_step) begin
      if (div_cnt_q) begin
        rem_q <= rem_fix[BW-1:0];
      end else begin
        quo_q <= prod[2*KeyW-1:KeyW];
      end
    end
    if (cmd_i.update) begin
      present_q  <= hit_any;
      overflow_q <= ovf;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == LastRow);
  assign sts_o.div_last = div_cnt_q;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_v[w]             = vld_row[w] && (key_row[w*KeyW +: KeyW] == key_q);
      free_v[w]            = !vld_row[w];
    end
  end

  assign hit_first  = hit_v & (~hit_v + WAYS'(1));
  assign free_first = free_v & (~free_v + WAYS'(1));
  assign hit_any    = |hit_v;
  assign free_any   = |free_v;
  assign is_ins     = (op_q == OP_INSERT);
  assign is_del     = (op_q == OP_DELETE);
  assign do_ins     = is_ins && !hit_any && free_any;
  assign do_del     = is_del && hit_any;
  assign ovf        = is_ins && !hit_any && !free_any;
  assign vld_new    = do_ins ? (vld_row | free_first) : (vld_row & ~hit_first);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_new[w*KeyW +: KeyW] = free_first[w] ? key_q : key_row[w*KeyW +: KeyW];
    end
  end

  assign vld_we    = cmd_i.clr || (cmd_i.update && (do_ins || do_del));
  assign vld_waddr = cmd_i.clr ? clr_cnt_q : rem_q;
  assign vld_wdata = cmd_i.clr ? '0 : vld_new;

  hsil_ram #(
    .Width (RowW),
    .Depth (BUCKETS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update && do_ins),
    .waddr_i (rem_q),
    .wdata_i (key_new),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (key_row)
  );

  hsil_ram #(
    .Width (WAYS),
    .Depth (BUCKETS)
  ) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (vld_row)
  );

  assign present_o  = present_q;
  assign overflow_o = overflow_q;

endmodule

@@ rtl/hsil_ctrl.sv @@
// ----------------------------------------------------------------------------
// hsil_ctrl
// Controller of the hash set: clear sweep after reset, request sequencing
// through remainder, bucket read and write-back, and the result handshake.
// ----------------------------------------------------------------------------
module hsil_ctrl #(
  parameter bit Pow2 = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  hsil_pkg::sts_t sts_i,
  output hsil_pkg::cmd_t cmd_o
);
  import hsil_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DIV    = 5'b00100,
    S_READ   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (Pow2) begin
            cmd_o.rd_en      = 1'b1;
            cmd_o.rd_from_in = 1'b1;
            state_d          = S_UPDATE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/hsil_chk.sv @@
// ----------------------------------------------------------------------------
// hsil_chk
// Port-level checker of the hash set, bound to the top level.
// ----------------------------------------------------------------------------
module hsil_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic signed [31:0] key_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               present_o,
  input logic               overflow_o
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(opcode_i) && $stable(key_i))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(present_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pend_q == 2'd0 || pend_q == 2'd1)
    else $error("request accepted with two outstanding");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(present_o && overflow_o))
    else $error("overflow reported for a present key");

endmodule

bind hash_set_insert_lookup_delete hsil_chk u_hsil_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bucketed hash set. A predictor keeps its own
// key and valid arrays and works out present and overflow for every accepted
// request. Directed tests cover the key extremes, every opcode, a full bucket
// and freed ways. A long output stall and random traffic over a few busy
// buckets follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hsil_pkg::*;

  localparam int Buckets     = 1024;
  localparam int Ways        = 4;
  localparam int Slots       = Buckets * Ways;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 1150;
  localparam int LimitCycles = 500000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    bit          present;
    bit          overflow;
  } lookup_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [31:0] key;
  logic               out_valid;
  logic               out_ready;
  logic               present;
  logic               overflow;

  logic [31:0] set_key   [Slots];
  bit          set_valid [Slots];
  lookup_t     pending_results[$];
  lookup_t     oldest;

  int unsigned cycle_count;
  int          burst_left;
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_present;
  int          n_dropped;
  bit          hold_req;

  hash_set_insert_lookup_delete #(
    .BUCKETS(Buckets),
    .WAYS   (Ways)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .opcode_i   (opcode),
    .key_i      (key),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .present_o  (present),
    .overflow_o (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic lookup_t hash_set_update(logic [1:0] op, logic [31:0] k);
    lookup_t     r;
    logic [31:0] mag;
    int          base;
    int          hit;
    int          free_way;
    mag      = k[31] ? (32'd0 - k) : k;
    base     = int'(mag % 32'(Buckets)) * Ways;
    hit      = -1;
    free_way = -1;
    for (int w = 0; w < Ways; w++) begin
      if (set_valid[base + w]) begin
        if (hit < 0 && set_key[base + w] == k) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    r.op       = op;
    r.key      = k;
    r.present  = (hit >= 0);
    r.overflow = 1'b0;
    if (op == OP_INSERT) begin
      if (hit < 0) begin
        if (free_way >= 0) begin
          set_key[base + free_way]   = k;
          set_valid[base + free_way] = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
    end else if (op == OP_DELETE && hit >= 0) begin
      set_valid[base + hit] = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic send_request(input logic [1:0] op, input logic [31:0] k);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(hash_set_update(op, k));
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result present=%b overflow=%b with no request open",
                                  present, overflow));
      end else begin
        oldest = pending_results.pop_front();
        n_checked++;
        if (oldest.present) n_present++;
        if (oldest.overflow) n_dropped++;
        if (present !== oldest.present)
          report_mismatch($sformatf("op %0d key %0d: present %b, want %b",
                                    oldest.op, $signed(oldest.key), present,
                                    oldest.present));
        if (overflow !== oldest.overflow)
          report_mismatch($sformatf("op %0d key %0d: overflow %b, want %b",
                                    oldest.op, $signed(oldest.key), overflow,
                                    oldest.overflow));
      end
    end
  end

  // Receiver: stall pattern in stretches, or one long hold-off on request.
  initial begin
    int stretch_left;
    int mode;
    out_ready    = 1'b0;
    stretch_left = 0;
    mode         = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 40);
        end
        stretch_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic test_basic_ops();
    send_request(OP_INSERT, 32'd17);
    send_request(OP_QUERY,  32'd17);
    send_request(OP_INSERT, 32'd17);
    send_request(OP_DELETE, 32'd17);
    send_request(OP_DELETE, 32'd17);
    send_request(OP_QUERY,  32'd17);
    send_request(OP_INSERT, 32'd17);
    send_request(OpUnused,  32'd17);
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, 32'd0);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_QUERY,  32'h8000_0000);
    send_request(OP_QUERY,  32'hffff_ffff);
  endtask

  task automatic test_full_bucket();
    send_request(OP_INSERT, 32'd5);
    send_request(OP_INSERT, -32'sd5);
    send_request(OP_INSERT, 32'd1029);
    send_request(OP_INSERT, -32'sd1029);
    send_request(OP_INSERT, 32'd2053);
    send_request(OP_DELETE, -32'sd5);
    send_request(OP_INSERT, 32'd2053);
    send_request(OP_QUERY,  32'd2053);
  endtask

  function automatic logic [31:0] pick_key(int unsigned hot[6]);
    logic [31:0] mag;
    if ($urandom_range(0, 99) < 75) begin
      mag = hot[$urandom_range(0, 5)] + Buckets * $urandom_range(0, 5);
      return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 70) return OP_QUERY;
    if (r < 95) return OP_DELETE;
    return OpUnused;
  endfunction

  task automatic test_backpressure();
    int unsigned hot[6];
    foreach (hot[i]) hot[i] = 7 + i;
    repeat (4) send_request(OP_QUERY, 32'd7);
    hold_req = 1'b1;
    repeat (24) send_request(pick_op(), pick_key(hot));
  endtask

  task automatic test_random_traffic();
    int unsigned hot[6];
    foreach (hot[i]) hot[i] = $urandom_range(0, Buckets - 1);
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 200 == 199) hot[$urandom_range(0, 5)] = $urandom_range(0, Buckets - 1);
      send_request(pick_op(), pick_key(hot));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    opcode      = OP_QUERY;
    key         = '0;
    hold_req    = 1'b0;
    cycle_count = 0;
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_present   = 0;
    n_dropped   = 0;
    burst_left  = 4;
    foreach (set_valid[i]) begin
      set_valid[i] = 1'b0;
      set_key[i]   = '0;
    end
    repeat (8) @(negedge clk);
    rst_ni = 1'b1;

    test_basic_ops();
    test_key_extremes();
    test_full_bucket();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d insert/query/delete requests, %0d results checked.", n_sent, n_checked);
    $display("Keys found present: %0d, inserts dropped on full buckets: %0d.",
             n_present, n_dropped);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
